[design/assert_macros.svh]
// Assertion macros used by the checker file lpif_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition c at the same clock edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");

// Condition a implies condition c at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

[design/lpif_pkg.sv]
// Shared types, codes and helper functions of the LUT prime implicant finder.
// No dependencies.
package lpif_pkg;

  localparam int ROUNDS    = 7;
  localparam int LIT_W     = 6;
  localparam int CUBE_W    = 13;
  localparam int MERGED_B  = 12;
  localparam int MAX_PICK  = 128;
  localparam int OUT_DATA_W = 32;

  typedef logic [CUBE_W-1:0] cube_t;

  localparam logic [1:0] KIND_PAIR  = 2'd0;
  localparam logic [1:0] KIND_FALSE = 2'd1;
  localparam logic [1:0] KIND_TRUE  = 2'd2;

  localparam logic [1:0] CFG_LUT_BITS = 2'd0;
  localparam logic [1:0] CFG_BASE     = 2'd1;
  localparam logic [1:0] CFG_FLIP     = 2'd2;

  localparam logic [6:0]       LUT_BITS_RST = 7'd64;
  localparam logic [LIT_W-1:0] BASE_RST     = 6'd34;

  // Literal values of minterm idx: care all literals, polarity per mapping.
  function automatic cube_t encode_minterm(input logic [5:0] idx,
                                           input logic [5:0] base,
                                           input logic flip);
    logic [5:0] v;
    v = base ^ (idx & 6'h3B);
    if (idx[3] ^ idx[2]) v[2] = 1'b1;
    if (flip && (v[2] ^ v[3])) v[0] = ~v[0];
    return {1'b0, v, 6'h3F};
  endfunction

  // Literals in which two cubes differ (care or polarity).
  function automatic logic [LIT_W-1:0] cube_diff(input cube_t a, input cube_t b);
    logic [11:0] x;
    x = a[11:0] ^ b[11:0];
    return x[5:0] | x[11:6];
  endfunction

endpackage

[design/lpif_cube_mem.sv]
// Cube store: one write port, one registered read port.
// Uses lpif_pkg for the cube type.
module lpif_cube_mem #(
  parameter int AW = 11
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lpif_pkg::cube_t      wr_data,
  input  logic [AW-1:0]        rd_addr,
  output lpif_pkg::cube_t      rd_data
);
  import lpif_pkg::*;

  localparam int IW    = AW - 3;
  localparam int DEPTH = ROUNDS << IW;

  cube_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/lut_prime_implicant_finder_top.sv]
// Top level of the LUT prime implicant finder (Quine-McCluskey, six literals).
// Uses lpif_pkg and lpif_cube_mem.
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tdata = lut (64 bits)
//  out_    | master    | tdata = implicant pair + overflow, tuser = kind, tlast
//  cfg_    | slave     | cfg_index = register, cfg_data = value
//
// One truth table at a time: minterm fill, then per round every pair of cubes
// is compared and each merged cube is looked up in the table being built (the
// single read port of the cube store serializes this), then the stored entries
// are read out and the unmerged ones are sent.
// rst_n is synchronous; the cube store is not cleared, every entry is written
// before it is read. An output stall holds the walk until the result is taken.
module lut_prime_implicant_finder_top #(
  parameter int CUBES_PER_ROUND = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] lut
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] first_care, [11:6] first_polarity, [12] second_valid,
  // [18:13] second_care, [24:19] second_polarity, [25] overflow, [31:26] zero
  output logic [lpif_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import lpif_pkg::*;

  localparam int IW = $clog2(CUBES_PER_ROUND);
  localparam int CW = $clog2(CUBES_PER_ROUND + 1);
  localparam int AW = IW + 3;
  localparam int TW = IW + 3;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_RSTART, S_I, S_IW, S_JRD, S_JW, S_KRD, S_KW,
    S_MARK, S_IEND, S_FINAL, S_ERD, S_EW, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [6:0]       lut_bits_r;
  logic [LIT_W-1:0] base_r;
  logic             flip_r;

  // walk control
  logic [63:0]   lut_r;
  logic [5:0]    fi_r;
  logic [2:0]    rnd_r;
  logic [CW-1:0] n_prev_r, n_cur_r, i_r, j_r, k_r;
  logic [CW-1:0] cnt_r [ROUNDS];
  logic [TW-1:0] total_r, marked_r;
  logic          ovf_r, a_mark_r;
  logic [7:0]    npick_r, picked_r;
  logic [2:0]    er_r;
  logic [CW-1:0] idx_r;
  logic          have_first_r;

  // payload
  cube_t a_r, b_r, nc_r;
  logic [11:0] first_r, sec_r;
  logic        sec_valid_r, last_r;
  logic [1:0]  kind_r;

  // cube store port
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  cube_t         wr_data, rd_data;

  logic [LIT_W-1:0] d;
  logic             mergeable;
  logic [6:0]       nbits;
  logic [TW-1:0]    unmerged;
  logic [2:0]       prev_rnd;

  lpif_cube_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'd0, ovf_r, sec_r[11:6], sec_r[5:0], sec_valid_r,
                       first_r[11:6], first_r[5:0]};

  assign nbits     = (lut_bits_r > 7'd64) ? 7'd64 : lut_bits_r;
  assign prev_rnd  = rnd_r - 3'd1;
  assign d         = cube_diff(a_r, rd_data);
  assign mergeable = (d != '0) && ((d & (d - 6'd1)) == '0);
  assign unmerged  = total_r - marked_r;

  // Store port: address and write data follow the state.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    unique case (state_r)
      S_FILL: begin
        wr_en   = lut_r[fi_r] && ({1'b0, fi_r} < nbits);
        wr_addr = {3'd0, n_cur_r[IW-1:0]};
        wr_data = encode_minterm(fi_r, base_r, flip_r);
      end
      S_I:   rd_addr = {prev_rnd, i_r[IW-1:0]};
      S_JRD: rd_addr = {prev_rnd, j_r[IW-1:0]};
      S_KRD: begin
        rd_addr = {rnd_r, k_r[IW-1:0]};
        wr_en   = (k_r == n_cur_r) && (n_cur_r != CW'(CUBES_PER_ROUND));
        wr_addr = {rnd_r, n_cur_r[IW-1:0]};
        wr_data = nc_r;
      end
      S_MARK: begin
        wr_en   = 1'b1;
        wr_addr = {prev_rnd, j_r[IW-1:0]};
        wr_data = b_r | (CUBE_W'(1) << MERGED_B);
      end
      S_IEND: begin
        wr_en   = a_mark_r && !a_r[MERGED_B];
        wr_addr = {prev_rnd, i_r[IW-1:0]};
        wr_data = a_r | (CUBE_W'(1) << MERGED_B);
      end
      S_ERD: rd_addr = {er_r, idx_r[IW-1:0]};
      default: ;
    endcase
  end

  // Config registers; host must write them between truth tables; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_bits_r <= LUT_BITS_RST;
      base_r     <= BASE_RST;
      flip_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LUT_BITS: lut_bits_r <= cfg_data;
        CFG_BASE:     base_r     <= cfg_data[LIT_W-1:0];
        CFG_FLIP:     flip_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: fill round 0, merge rounds 1-6, emit unmerged cubes or a constant.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fi_r         <= '0;
      rnd_r        <= '0;
      n_prev_r     <= '0;
      n_cur_r      <= '0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      total_r      <= '0;
      marked_r     <= '0;
      ovf_r        <= 1'b0;
      a_mark_r     <= 1'b0;
      npick_r      <= '0;
      picked_r     <= '0;
      er_r         <= '0;
      idx_r        <= '0;
      have_first_r <= 1'b0;
      last_r       <= 1'b0;
      kind_r       <= KIND_PAIR;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            fi_r     <= '0;
            rnd_r    <= '0;
            n_cur_r  <= '0;
            total_r  <= '0;
            marked_r <= '0;
            ovf_r    <= 1'b0;
            state_r  <= S_FILL;
          end
        end
        S_FILL: begin
          if (lut_r[fi_r] && ({1'b0, fi_r} < nbits)) n_cur_r <= n_cur_r + 1'b1;
          fi_r <= fi_r + 1'b1;
          if (fi_r == 6'd63) state_r <= S_RSTART;
        end
        S_RSTART: begin
          total_r  <= total_r + TW'(n_cur_r);
          n_prev_r <= n_cur_r;
          n_cur_r  <= '0;
          i_r      <= '0;
          last_r   <= 1'b1;
          if (rnd_r == 3'd0 && n_cur_r == '0) begin
            kind_r  <= KIND_FALSE;
            state_r <= S_OUT;
          end else if (rnd_r == 3'(ROUNDS - 1)) begin
            if (n_cur_r != '0) begin
              kind_r  <= KIND_TRUE;
              state_r <= S_OUT;
            end else begin
              state_r <= S_FINAL;
            end
          end else begin
            rnd_r   <= rnd_r + 3'd1;
            state_r <= S_I;
          end
        end
        S_I: begin
          if ((i_r + 1'b1) >= n_prev_r) state_r <= S_RSTART;
          else state_r <= S_IW;
        end
        S_IW: begin
          a_mark_r <= 1'b0;
          j_r      <= i_r + 1'b1;
          state_r  <= S_JRD;
        end
        S_JRD: begin
          if (j_r == n_prev_r) state_r <= S_IEND;
          else state_r <= S_JW;
        end
        S_JW: begin
          k_r <= '0;
          if (mergeable) begin
            state_r <= S_KRD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_JRD;
          end
        end
        S_KRD: begin
          if (k_r == n_cur_r) begin
            if (n_cur_r == CW'(CUBES_PER_ROUND)) ovf_r <= 1'b1;
            else n_cur_r <= n_cur_r + 1'b1;
            state_r <= S_MARK;
          end else begin
            state_r <= S_KW;
          end
        end
        S_KW: begin
          if (rd_data[11:0] == nc_r[11:0]) begin
            state_r <= S_MARK;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_KRD;
          end
        end
        S_MARK: begin
          // count each cube once, when its merged bit first goes up
          marked_r <= marked_r + TW'(!b_r[MERGED_B])
                               + TW'(!a_r[MERGED_B] && !a_mark_r);
          a_mark_r <= 1'b1;
          j_r      <= j_r + 1'b1;
          state_r  <= S_JRD;
        end
        S_IEND: begin
          i_r     <= i_r + 1'b1;
          state_r <= S_I;
        end
        S_FINAL: begin
          if (unmerged > TW'(MAX_PICK)) begin
            ovf_r   <= 1'b1;
            npick_r <= 8'(MAX_PICK);
          end else begin
            npick_r <= unmerged[7:0];
          end
          picked_r     <= '0;
          er_r         <= '0;
          idx_r        <= '0;
          have_first_r <= 1'b0;
          kind_r       <= KIND_PAIR;
          state_r      <= S_ERD;
        end
        S_ERD: begin
          if (idx_r == cnt_r[er_r]) begin
            er_r  <= er_r + 3'd1;
            idx_r <= '0;
          end else begin
            state_r <= S_EW;
          end
        end
        S_EW: begin
          idx_r <= idx_r + 1'b1;
          if (rd_data[MERGED_B]) begin
            state_r <= S_ERD;
          end else begin
            picked_r <= picked_r + 8'd1;
            last_r   <= (picked_r + 8'd1 == npick_r);
            if (!have_first_r) begin
              have_first_r <= 1'b1;
              state_r      <= (picked_r + 8'd1 == npick_r) ? S_OUT : S_ERD;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_tready) begin
            have_first_r <= 1'b0;
            state_r      <= last_r ? S_IDLE : S_ERD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload and per-round counts; no reset needed.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) lut_r <= in_tdata;
    if (state_r == S_RSTART) begin
      cnt_r[rnd_r] <= n_cur_r;
      first_r      <= '0;
      sec_r        <= '0;
      sec_valid_r  <= 1'b0;
    end
    if (state_r == S_IW) a_r <= rd_data;
    if (state_r == S_JW) begin
      b_r  <= rd_data;
      nc_r <= {1'b0, a_r[11:6] & a_r[5:0] & ~d, a_r[5:0] & ~d};
    end
    if (state_r == S_EW && !rd_data[MERGED_B]) begin
      if (!have_first_r) begin
        first_r     <= rd_data[11:0];
        sec_r       <= '0;
        sec_valid_r <= 1'b0;
      end else begin
        sec_r       <= rd_data[11:0];
        sec_valid_r <= 1'b1;
      end
    end
  end

endmodule

[design/lpif_checker.sv]
// Port-level checks of the LUT prime implicant finder, bound to its top level.
// Uses lpif_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpif_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [lpif_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import lpif_pkg::*;

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // a constant answer is always the only result of its truth table
  `ASSERT_IMPLY(a_const_last, clk, rst_n, out_tvalid && out_tuser != KIND_PAIR, out_tlast)
  // constant false carries no cubes and no overflow
  `ASSERT_IMPLY(a_false_empty, clk, rst_n,
                out_tvalid && out_tuser == KIND_FALSE, out_tdata == '0)
  // a taken request keeps the input side closed while it is worked on
  `ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind lut_prime_implicant_finder_top lpif_port_checker u_lpif_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
